FILE: rtl/point_rotate_about_origin_defines.svh
// ---------------------------------------------------------------------------
// point rotate about origin - assertion macros
// concurrent assertion wrappers, compiled out when ASSERT_OFF is set
// ---------------------------------------------------------------------------
`ifndef POINT_ROTATE_ABOUT_ORIGIN_DEFINES_SVH
`define POINT_ROTATE_ABOUT_ORIGIN_DEFINES_SVH

`ifndef ASSERT_OFF
// property must hold at every clock edge outside reset
`define PRA_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// expression must never be true outside reset
`define PRA_ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define PRA_ASSERT(lbl, clk, rst_n, prop, msg)
`define PRA_ASSERT_NEVER(lbl, clk, rst_n, expr, msg)
`endif

`endif

FILE: rtl/pra_pkg.sv
// ---------------------------------------------------------------------------
// pra_pkg
// shared constants for the cordic point rotator
// ---------------------------------------------------------------------------
package pra_pkg;

  localparam int COORD_BITS_DEF      = 32;
  localparam int ANGLE_BITS_DEF      = 16;
  localparam int ROTATION_STAGES_DEF = 16;
  localparam int GUARD_BITS          = 8;
  localparam int THRESH_W            = 16;
  localparam int TURN_W              = 32;

  // 1/K of the cordic gain as a 32-bit fraction
  localparam logic [31:0] INV_GAIN_Q32 = 32'd2608131496;

  // atan(2^-i) in units of 2^-32 turn
  localparam logic [31:0] ATAN_TURNS [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
  };

endpackage

FILE: rtl/point_rotate_about_origin.sv
// throughput: one point per cycle, busy is never raised; every stage is a register,
// so a new start transfer can be taken in each cycle
// results are strobed for one cycle each, the receiver cannot stall
// reset (rst_n, synchronous) clears the valid line and sets the snap threshold to 0
// ---------------------------------------------------------------------------
// point_rotate_about_origin
// pipelined cordic rotation of a Q16.16 point about a pivot, with saturation
// and zero snapping of small result coordinates
// ---------------------------------------------------------------------------
`include "point_rotate_about_origin_defines.svh"

module point_rotate_about_origin #(
  parameter int COORD_BITS      = pra_pkg::COORD_BITS_DEF,
  parameter int ANGLE_BITS      = pra_pkg::ANGLE_BITS_DEF,
  parameter int ROTATION_STAGES = pra_pkg::ROTATION_STAGES_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [COORD_BITS-1:0] in_point_x,
  input  logic signed [COORD_BITS-1:0] in_point_y,
  input  logic signed [COORD_BITS-1:0] in_pivot_x,
  input  logic signed [COORD_BITS-1:0] in_pivot_y,
  input  logic [ANGLE_BITS-1:0]        in_angle,
  output logic                         out_valid,
  output logic signed [COORD_BITS-1:0] out_rotated_x,
  output logic signed [COORD_BITS-1:0] out_rotated_y,
  input  logic                         cfg_wr_en,
  input  logic [pra_pkg::THRESH_W-1:0] cfg_wr_data
);
  import pra_pkg::*;

  localparam int C     = COORD_BITS;
  localparam int N     = ROTATION_STAGES;
  localparam int W     = C + GUARD_BITS + 4;          // cordic datapath width
  localparam int HI_W  = (W > 32) ? (W - 32) : 1;     // upper multiplier slice
  localparam int MAG_W = 32 + HI_W;
  localparam int SUM_W = HI_W + 33;
  localparam int RW    = C + 5;                       // width before saturation
  localparam int PIV_D = N + 5;                       // pivot taps through stage G
  localparam int VLD_D = N + 6;                       // valid taps through stage P
  localparam int LAT   = N + 7;

  localparam logic signed [RW-1:0] SAT_HI = {{(RW-C+1){1'b0}}, {(C-1){1'b1}}};
  localparam logic signed [RW-1:0] SAT_LO = {{(RW-C+1){1'b1}}, {(C-1){1'b0}}};

  logic                  accept;
  logic [THRESH_W-1:0]   thr_r;
  logic                  vld_r [VLD_D];
  logic                  out_valid_r;
  logic signed [C-1:0]   piv_r [PIV_D][2];
  logic signed [W-1:0]   x_r [N+1];
  logic signed [W-1:0]   y_r [N+1];
  logic signed [31:0]    z_r [N+1];
  logic signed [C-1:0]   res_r [2];

  // input stage signals
  logic [TURN_W-1:0]     turn;
  logic [TURN_W-1:0]     turn_bias;
  logic [1:0]            quad;
  logic [TURN_W-1:0]     resid;
  logic signed [C:0]     dx;
  logic signed [C:0]     dy;
  logic signed [C:0]     qx;
  logic signed [C:0]     qy;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= '0;
    end else if (cfg_wr_en) begin
      thr_r <= cfg_wr_data;
    end
  end

  // valid line, one bit per stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < VLD_D; j++) vld_r[j] <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      vld_r[0] <= accept;
      for (int j = 1; j < VLD_D; j++) vld_r[j] <= vld_r[j-1];
      out_valid_r <= vld_r[VLD_D-1];
    end
  end

  always_ff @(posedge clk) begin
    piv_r[0][0] <= in_pivot_x;
    piv_r[0][1] <= in_pivot_y;
    for (int j = 1; j < PIV_D; j++) begin
      piv_r[j][0] <= piv_r[j-1][0];
      piv_r[j][1] <= piv_r[j-1][1];
    end
  end

  // quadrant step and pivot offset
  always_comb begin
    turn      = {in_angle, {(TURN_W-ANGLE_BITS){1'b0}}};
    turn_bias = turn + 32'h2000_0000;
    quad      = turn_bias[31:30];
    resid     = turn - {quad, 30'b0};
    dx        = {in_point_x[C-1], in_point_x} - {in_pivot_x[C-1], in_pivot_x};
    dy        = {in_point_y[C-1], in_point_y} - {in_pivot_y[C-1], in_pivot_y};
    case (quad)
      2'd0: begin
        qx = dx;
        qy = dy;
      end
      2'd1: begin
        qx = -dy;
        qy = dx;
      end
      2'd2: begin
        qx = -dx;
        qy = -dy;
      end
      default: begin
        qx = dy;
        qy = -dx;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    x_r[0] <= {{(W-C-1-GUARD_BITS){qx[C]}}, qx, {GUARD_BITS{1'b0}}};
    y_r[0] <= {{(W-C-1-GUARD_BITS){qy[C]}}, qy, {GUARD_BITS{1'b0}}};
    z_r[0] <= $signed(resid);
  end

  // micro-rotation stages
  for (genvar i = 0; i < N; i++) begin : g_stage
    logic signed [W-1:0] xs;
    logic signed [W-1:0] ys;
    assign xs = x_r[i] >>> i;
    assign ys = y_r[i] >>> i;
    always_ff @(posedge clk) begin
      if (!z_r[i][31]) begin
        x_r[i+1] <= x_r[i] - ys;
        y_r[i+1] <= y_r[i] + xs;
        z_r[i+1] <= z_r[i] - $signed(ATAN_TURNS[i]);
      end else begin
        x_r[i+1] <= x_r[i] + ys;
        y_r[i+1] <= y_r[i] - xs;
        z_r[i+1] <= z_r[i] + $signed(ATAN_TURNS[i]);
      end
    end
  end

  // gain removal, rounding, pivot add, saturation and zero snapping, one lane per coordinate
  for (genvar l = 0; l < 2; l++) begin : g_lane
    logic signed [W-1:0]     src;
    logic [W-1:0]            mag_nxt;
    logic                    neg_a_r, neg_m_r, neg_s_r;
    logic [MAG_W-1:0]        mag_a_r;
    logic [63:0]             plo_nxt;
    logic [SUM_W-2:0]        phi_nxt;
    logic [63:0]             plo_r;
    logic [SUM_W-2:0]        phi_r;
    logic [64:0]             plo_rnd;
    logic [SUM_W-1:0]        psum;
    logic [W-1:0]            p_s_r;
    logic signed [W-1:0]     v_g_r;
    logic signed [W-1:0]     v_rnd;
    logic signed [RW-1:0]    r_nxt;
    logic signed [RW-1:0]    r_p_r;
    logic signed [RW-1:0]    sat;
    logic signed [RW-1:0]    thr_s;
    logic signed [C-1:0]     res_nxt;

    assign src     = (l == 0) ? x_r[N] : y_r[N];
    assign mag_nxt = src[W-1] ? W'(-src) : W'(src);

    always_ff @(posedge clk) begin
      neg_a_r <= src[W-1];
      mag_a_r <= MAG_W'(mag_nxt);
    end

    // magnitude times 1/K split into partial products of the low 32 bits and the upper slice
    assign plo_nxt = 64'(mag_a_r[31:0]) * 64'(INV_GAIN_Q32);
    assign phi_nxt = (SUM_W-1)'(mag_a_r[MAG_W-1:32]) * (SUM_W-1)'(INV_GAIN_Q32);

    always_ff @(posedge clk) begin
      neg_m_r <= neg_a_r;
      plo_r   <= plo_nxt;
      phi_r   <= phi_nxt;
    end

    // round to nearest on the magnitude
    assign plo_rnd = {1'b0, plo_r} + 65'h0_8000_0000;
    assign psum    = {1'b0, phi_r} + SUM_W'(plo_rnd[64:32]);

    always_ff @(posedge clk) begin
      neg_s_r <= neg_m_r;
      p_s_r   <= psum[W-1:0];
    end

    always_ff @(posedge clk) begin
      v_g_r <= neg_s_r ? $signed(-p_s_r) : $signed(p_s_r);
    end

    // drop guard bits rounding half up, then restore the pivot
    assign v_rnd = v_g_r + W'(1 << (GUARD_BITS - 1));
    assign r_nxt = {{(RW-W+GUARD_BITS){v_rnd[W-1]}}, v_rnd[W-1:GUARD_BITS]}
                 + {{(RW-C){piv_r[PIV_D-1][l][C-1]}}, piv_r[PIV_D-1][l]};

    always_ff @(posedge clk) begin
      r_p_r <= r_nxt;
    end

    assign thr_s = $signed({{(RW-THRESH_W){1'b0}}, thr_r});

    always_comb begin
      if (r_p_r > SAT_HI) begin
        sat = SAT_HI;
      end else if (r_p_r < SAT_LO) begin
        sat = SAT_LO;
      end else begin
        sat = r_p_r;
      end
      if (sat > -thr_s && sat < thr_s) begin
        res_nxt = '0;
      end else begin
        res_nxt = sat[C-1:0];
      end
    end

    always_ff @(posedge clk) begin
      res_r[l] <= res_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_rotated_x = res_r[0];
  assign out_rotated_y = res_r[1];

  // checks
  logic signed [C:0] chk_x;
  logic signed [C:0] chk_thr;
  assign chk_x   = {out_rotated_x[C-1], out_rotated_x};
  assign chk_thr = $signed({{(C+1-THRESH_W){1'b0}}, thr_r});

  `PRA_ASSERT(a_strobe_follows_start, clk, rst_n, out_valid |-> $past(start, LAT), "result strobe without a start transfer")
  `PRA_ASSERT(a_no_busy, clk, rst_n, !busy, "busy raised")
  `PRA_ASSERT_NEVER(a_snap_window, clk, rst_n, out_valid && chk_x != 0 && chk_x > -chk_thr && chk_x < chk_thr, "small x coordinate not snapped")

endmodule
